/* sv/cwrq_pkg.sv */
// Package for the completion waiter release queue: constants, codes, entry type, helpers.
package cwrq_pkg;

	// Default queue depth
	localparam int unsigned QUEUE_DEPTH = 64;

	// Half of the 32-bit counter range, used by the wrap test
	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

	// Origin code of a zero-copy completion message
	localparam logic [7:0] ORIGIN_ZEROCOPY = 8'd5;

	// Request commands
	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_MESSAGE = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Event kinds on the result channel
	typedef enum logic [1:0] {
		KIND_DONE    = 2'd0,
		KIND_WRAP    = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_REFUSED = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BACK,
		ST_POP,
		ST_FLUSH
	} state_t;

	// One queue entry as stored in the waiter RAM
	typedef struct packed {
		logic [31:0] number;
		logic [7:0]  tag;
	} waiter_t;

	// True when newer appears wrapped against older
	function automatic logic appears_wrapped(input logic [31:0] older, input logic [31:0] newer);
		logic [31:0] diff;
		diff = newer - older;
		return (diff > HALF_RANGE) && (older > HALF_RANGE);
	endfunction

endpackage

/* sv/cwrq_req_if.sv */
// Request channel interface: commands and waiters into the queue.
interface cwrq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] count_value;
	logic [7:0]  waiter_tag;
	logic [7:0]  origin;
	logic [7:0]  error_code;
	logic        batch_end;

	modport source (
		output valid, cmd, count_value, waiter_tag, origin, error_code, batch_end,
		input  ready
	);
	modport sink (
		input  valid, cmd, count_value, waiter_tag, origin, error_code, batch_end,
		output ready
	);
endinterface

/* sv/cwrq_rsp_if.sv */
// Result channel interface: released or refused waiters out of the queue.
interface cwrq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] released_tag;
	logic [1:0] event_kind;
	logic       last_in_run;

	modport source (
		output valid, released_tag, event_kind, last_in_run,
		input  ready
	);
	modport sink (
		input  valid, released_tag, event_kind, last_in_run,
		output ready
	);
endinterface

/* sv/cwrq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cwrq_ram #(
	parameter int unsigned WIDTH = 40,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/completion_waiter_release_queue_top.sv */
// Top level of the completion waiter release queue: sequencer, queue pointers and result register.
//
// The req channel carries one request per handshake: enqueue a waiter (number and tag),
// a completion message (counter value, origin, error code, batch end mark) or a timeout.
// The rsp channel carries one result per released or refused waiter: its tag, the event
// kind and a mark on the last result that one request causes.
// Waiters live in a single RAM with registered read, so the sequencer reads one entry a
// cycle while the receiver takes results. An enqueue or a message that does not end a
// batch is handled in the idle state. A clean batch end reads the newest waiter for the
// wrap test in ST_BACK, then releases waiters in ST_POP and hands over the last result;
// a timeout skips ST_BACK. A refused enqueue goes to ST_FLUSH. The RAM read port sets the pace.
// req.ready is high only while the sequencer is idle; one result register separates the
// sides, so a stalled receiver holds the sequencer at the next result and no result is
// lost. Reset empties the queue and clears the batch state at once; the RAM contents are
// not cleared and are never read before they are written.
module completion_waiter_release_queue_top #(
	parameter int unsigned QUEUE_DEPTH = cwrq_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	cwrq_req_if.sink         req,
	cwrq_rsp_if.source       rsp
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EW = $bits(cwrq_pkg::waiter_t);

	cwrq_pkg::state_t  state_q, state_d;
	logic [AW-1:0]     head_q, head_d;
	logic [AW-1:0]     tail_q, tail_d;
	logic [OW-1:0]     occ_q, occ_d;
	logic [31:0]       cnt_q, cnt_d;
	logic [31:0]       prev_q, prev_d;
	logic              poison_q, poison_d;
	logic [31:0]       rel_cnt_q, rel_cnt_d;
	logic              all_q, all_d;
	cwrq_pkg::kind_t   kind_q, kind_d;
	logic [7:0]        pend_tag_q, pend_tag_d;
	logic              have_pend_q, have_pend_d;

	logic              out_valid_q;
	logic [7:0]        out_tag_q;
	cwrq_pkg::kind_t   out_kind_q;
	logic              out_last_q;

	logic              emit;
	logic              emit_last;
	logic              slot_free;
	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	cwrq_pkg::waiter_t ram_wdata;
	cwrq_pkg::waiter_t ram_rdata;
	logic [EW-1:0]     ram_rdata_raw;

	cwrq_pkg::cmd_t    req_cmd;
	logic              msg_bad;
	logic              msg_take;
	logic [31:0]       msg_cnt;
	logic [31:0]       msg_prev;
	logic              msg_poison;
	logic              back_wrapped;
	logic              pop_take;
	logic [AW-1:0]     back_idx;

	// Advance a queue index with wrap at the depth
	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
		return (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	// Waiter storage
	cwrq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = cwrq_pkg::waiter_t'(ram_rdata_raw);
	assign ram_wdata = '{number: req.count_value, tag: req.waiter_tag};
	assign req_cmd   = cwrq_pkg::cmd_t'(req.cmd);
	assign slot_free = !out_valid_q || rsp.ready;
	assign back_idx  = (tail_q == '0) ? AW'(QUEUE_DEPTH - 1) : tail_q - AW'(1);

	// Fold one completion message into the batch state
	assign msg_bad    = (req.origin != cwrq_pkg::ORIGIN_ZEROCOPY) || (req.error_code != 8'd0);
	assign msg_take   = (req.count_value > cnt_q) ||
		cwrq_pkg::appears_wrapped(prev_q, req.count_value);
	assign msg_poison = poison_q || msg_bad;
	assign msg_cnt    = (!poison_q && !msg_bad && msg_take) ? req.count_value : cnt_q;
	assign msg_prev   = (!poison_q && !msg_bad) ? req.count_value : prev_q;

	// Release tests on the RAM read data
	assign back_wrapped = cwrq_pkg::appears_wrapped(ram_rdata.number, rel_cnt_q);
	assign pop_take     = all_q || (ram_rdata.number <= rel_cnt_q);

	// Next state, pointers and result hand-over
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		occ_d       = occ_q;
		cnt_d       = cnt_q;
		prev_d      = prev_q;
		poison_d    = poison_q;
		rel_cnt_d   = rel_cnt_q;
		all_d       = all_q;
		kind_d      = kind_q;
		pend_tag_d  = pend_tag_q;
		have_pend_d = have_pend_q;
		ram_we      = 1'b0;
		ram_raddr   = head_q;
		emit        = 1'b0;
		emit_last   = 1'b0;
		req.ready   = 1'b0;

		unique case (state_q)
			cwrq_pkg::ST_IDLE: begin
				req.ready   = 1'b1;
				have_pend_d = 1'b0;
				if (req.valid) begin
					unique case (req_cmd)
						cwrq_pkg::CMD_ENQUEUE: begin
							if (occ_q == OW'(QUEUE_DEPTH)) begin
								pend_tag_d = req.waiter_tag;
								kind_d     = cwrq_pkg::KIND_REFUSED;
								state_d    = cwrq_pkg::ST_FLUSH;
							end else begin
								ram_we = 1'b1;
								tail_d = idx_inc(tail_q);
								occ_d  = occ_q + OW'(1);
							end
						end
						cwrq_pkg::CMD_MESSAGE: begin
							cnt_d    = msg_cnt;
							prev_d   = msg_prev;
							poison_d = msg_poison;
							if (req.batch_end) begin
								cnt_d    = '0;
								prev_d   = '0;
								poison_d = 1'b0;
								if (!msg_poison && occ_q != '0) begin
									rel_cnt_d = msg_cnt;
									ram_raddr = back_idx;
									state_d   = cwrq_pkg::ST_BACK;
								end
							end
						end
						cwrq_pkg::CMD_TIMEOUT: begin
							if (occ_q != '0) begin
								all_d   = 1'b1;
								kind_d  = cwrq_pkg::KIND_TIMEOUT;
								state_d = cwrq_pkg::ST_POP;
							end
						end
						cwrq_pkg::CMD_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			cwrq_pkg::ST_BACK: begin
				// Newest waiter is in the read data; choose release-all or compare run
				all_d   = back_wrapped;
				kind_d  = back_wrapped ? cwrq_pkg::KIND_WRAP : cwrq_pkg::KIND_DONE;
				state_d = cwrq_pkg::ST_POP;
			end
			cwrq_pkg::ST_POP: begin
				if (pop_take) begin
					// Hand over the held result before taking the next waiter
					if (!have_pend_q || slot_free) begin
						emit        = have_pend_q;
						pend_tag_d  = ram_rdata.tag;
						have_pend_d = 1'b1;
						head_d      = idx_inc(head_q);
						occ_d       = occ_q - OW'(1);
						ram_raddr   = idx_inc(head_q);
						if (occ_q == OW'(1)) begin
							state_d = cwrq_pkg::ST_FLUSH;
						end
					end
				end else if (!have_pend_q) begin
					state_d = cwrq_pkg::ST_IDLE;
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = cwrq_pkg::ST_IDLE;
				end
			end
			cwrq_pkg::ST_FLUSH: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = cwrq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cwrq_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer and queue control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cwrq_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			cnt_q       <= '0;
			prev_q      <= '0;
			poison_q    <= 1'b0;
			all_q       <= 1'b0;
			have_pend_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			occ_q       <= occ_d;
			cnt_q       <= cnt_d;
			prev_q      <= prev_d;
			poison_q    <= poison_d;
			all_q       <= all_d;
			have_pend_q <= have_pend_d;
		end
	end

	// Run payload registers
	always_ff @(posedge clk) begin
		rel_cnt_q  <= rel_cnt_d;
		kind_q     <= kind_d;
		pend_tag_q <= pend_tag_d;
	end

	// Result register: load on hand-over, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_tag_q  <= pend_tag_q;
			out_kind_q <= kind_q;
			out_last_q <= emit_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.released_tag = out_tag_q;
	assign rsp.event_kind   = out_kind_q;
	assign rsp.last_in_run  = out_last_q;

endmodule
